// File: src/linear_interp_upsampler_macros.svh
// Assertion helpers used by the checker file of the upsampler.
// Every assertion is sampled on the rising edge of aclk and is switched
// off while aresetn is low.
`ifndef LINEAR_INTERP_UPSAMPLER_MACROS_SVH
`define LINEAR_INTERP_UPSAMPLER_MACROS_SVH

// Plain clocked assertion on a property expression.
`define LIU_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define LIU_ASSERT_NEXT(lbl, cond, conseq, msg) \
    `LIU_ASSERT_CLK(lbl, (cond) |=> (conseq), msg)

`endif

// File: src/liu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package liu_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MAX_FACTOR_DEF   = 48;

    // Configuration port layout.
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_FACTOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE     = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FACTOR_RESET = 6'd1;
    localparam logic                  STEREO_RESET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_L,
        ST_WAIT_L,
        ST_START_R,
        ST_WAIT_R,
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Sequencer commands to the datapath.
    typedef struct packed {
        logic s_ready;
        logic m_valid;
        logic div_start;
        logic div_right;
        logic cap_left;
        logic cap_right;
        logic load_out;
        logic step;
        logic finish;
    } liu_ctrl_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic in_accept;
        logic div_done;
        logic out_accept;
        logic last;
        logic stereo;
    } liu_stat_t;

endpackage

`default_nettype wire

// File: src/linear_interp_upsampler.sv
`timescale 1ns / 1ps
`default_nettype none

// Linear-interpolation upsampler. Each accepted input item carries one sample
// per channel; the block answers with R output items, pair k (k = 0..R-1)
// being prev + (k * (cur - prev)) / R with the quotient truncated toward zero,
// and the last of them flagged by m_last_of_run. The previous samples start
// at -1 after reset. R is the upsample_factor register, with 0 acting as 1 and
// values above MAX_FACTOR held at MAX_FACTOR. In mono mode only the left
// channel is interpolated and copied to the right output. One input item is
// handled at a time: the block takes no new item until the last output pair
// of its run is taken. The block has a single serial divider, shared by both
// channels, which resolves one quotient bit a cycle and divides each
// interpolated channel's step once per item; each output pair then passes
// through a load state and a present state, where it waits for m_ready.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce.
module linear_interp_upsampler #(
    parameter int SAMPLE_WIDTH = liu_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAX_FACTOR   = liu_pkg::MAX_FACTOR_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port.
    input  wire logic                             cfg_wr_en,
    input  wire logic [liu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [liu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input sample channel.
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   s_left_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   s_right_in,
    // Output sample channel.
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        m_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]        m_right_out,
    output logic                                  m_last_of_run
);
    import liu_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int CW = (FW > CFG_DATA_W) ? FW : CFG_DATA_W;

    liu_ctrl_t ctrl;
    liu_stat_t stat;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] factor_reg;
    logic                  stereo_reg;

    // Channel state and per-item operands.
    logic signed [SW-1:0] prev_l_reg, prev_r_reg;
    logic signed [SW-1:0] cur_l_reg, cur_r_reg;
    logic        [SW-1:0] mag_l_reg, mag_r_reg;
    logic                 neg_l_reg, neg_r_reg;
    logic        [FW-1:0] reff_reg;
    logic        [FW-1:0] k_reg;

    // Per-step increment (quotient and remainder of |diff| / R) and the
    // running quotient and remainder of k * |diff| / R for each channel.
    logic [SW-1:0] inc_q_l_reg, inc_q_r_reg;
    logic [FW-1:0] inc_r_l_reg, inc_r_r_reg;
    logic [SW-1:0] acc_q_l_reg, acc_q_r_reg, acc_q_l_next, acc_q_r_next;
    logic [FW-1:0] acc_r_l_reg, acc_r_r_reg, acc_r_l_next, acc_r_r_next;

    // Output registers.
    logic signed [SW-1:0] out_l_reg, out_r_reg;
    logic                 out_last_reg;

    logic [CW-1:0]        factor_ext;
    logic [FW-1:0]        reff;
    logic signed [SW:0]   diff_l, diff_r;
    logic [SW:0]          abs_l, abs_r;
    logic signed [SW:0]   val_l, val_r;
    logic                 last;
    logic [FW:0]          rsum_l, rsum_r;

    logic                 div_done;
    logic [SW-1:0]        div_q;
    logic [FW-1:0]        div_rem;
    logic [SW-1:0]        div_num;

    // Effective factor: zero behaves as one, large values clamp to the maximum.
    always_comb begin
        factor_ext = CW'(factor_reg);
        if (factor_ext == '0) begin
            reff = FW'(1);
        end else if (factor_ext > CW'(MAX_FACTOR)) begin
            reff = FW'(MAX_FACTOR);
        end else begin
            reff = factor_ext[FW-1:0];
        end
    end

    // The difference is kept one bit wider than a sample so it never wraps;
    // its magnitude always fits a sample width.
    always_comb begin
        diff_l = {s_left_in[SW-1], s_left_in} - {prev_l_reg[SW-1], prev_l_reg};
        diff_r = {s_right_in[SW-1], s_right_in} - {prev_r_reg[SW-1], prev_r_reg};
        abs_l  = diff_l[SW] ? (SW + 1)'(-diff_l) : diff_l;
        abs_r  = diff_r[SW] ? (SW + 1)'(-diff_r) : diff_r;
    end

    // Since k is never negative, truncation toward zero equals the sign of
    // the difference applied to the floor of the magnitude quotient.
    always_comb begin
        if (neg_l_reg) begin
            val_l = {prev_l_reg[SW-1], prev_l_reg} - {1'b0, acc_q_l_reg};
        end else begin
            val_l = {prev_l_reg[SW-1], prev_l_reg} + {1'b0, acc_q_l_reg};
        end
        if (neg_r_reg) begin
            val_r = {prev_r_reg[SW-1], prev_r_reg} - {1'b0, acc_q_r_reg};
        end else begin
            val_r = {prev_r_reg[SW-1], prev_r_reg} + {1'b0, acc_q_r_reg};
        end
        last = (k_reg == reff_reg - FW'(1));
    end

    // Moving from pair k to pair k+1 adds the per-step quotient and
    // remainder, with one carry when the remainder reaches R.
    always_comb begin
        rsum_l       = {1'b0, acc_r_l_reg} + {1'b0, inc_r_l_reg};
        rsum_r       = {1'b0, acc_r_r_reg} + {1'b0, inc_r_r_reg};
        acc_q_l_next = acc_q_l_reg + inc_q_l_reg;
        acc_q_r_next = acc_q_r_reg + inc_q_r_reg;
        acc_r_l_next = rsum_l[FW-1:0];
        acc_r_r_next = rsum_r[FW-1:0];
        if (rsum_l >= {1'b0, reff_reg}) begin
            acc_r_l_next = FW'(rsum_l - {1'b0, reff_reg});
            acc_q_l_next = acc_q_l_reg + inc_q_l_reg + SW'(1);
        end
        if (rsum_r >= {1'b0, reff_reg}) begin
            acc_r_r_next = FW'(rsum_r - {1'b0, reff_reg});
            acc_q_r_next = acc_q_r_reg + inc_q_r_reg + SW'(1);
        end
    end

    assign div_num = ctrl.div_right ? mag_r_reg : mag_l_reg;

    liu_div #(
        .NUM_W (SW),
        .DEN_W (FW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctrl.div_start),
        .dividend  (div_num),
        .divisor   (reff_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    assign stat.in_accept  = s_valid && ctrl.s_ready;
    assign stat.div_done   = div_done;
    assign stat.out_accept = ctrl.m_valid && m_ready;
    assign stat.last       = out_last_reg;
    assign stat.stereo     = stereo_reg;

    liu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Configuration and the previous samples are state that reset defines.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
            stereo_reg <= STEREO_RESET;
            prev_l_reg <= '1;
            prev_r_reg <= '1;
        end else begin
            if (cfg_wr_en && cfg_index == REG_UPSAMPLE_FACTOR) begin
                factor_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == REG_STEREO_MODE) begin
                stereo_reg <= cfg_wdata[0];
            end
            if (ctrl.finish) begin
                prev_l_reg <= cur_l_reg;
                if (stereo_reg) begin
                    prev_r_reg <= cur_r_reg;
                end
            end
        end
    end

    // Working registers; the sequencer always loads them before use.
    always_ff @(posedge aclk) begin
        if (stat.in_accept) begin
            cur_l_reg   <= s_left_in;
            cur_r_reg   <= s_right_in;
            mag_l_reg   <= abs_l[SW-1:0];
            mag_r_reg   <= abs_r[SW-1:0];
            neg_l_reg   <= diff_l[SW];
            neg_r_reg   <= diff_r[SW];
            reff_reg    <= reff;
            k_reg       <= '0;
            acc_q_l_reg <= '0;
            acc_q_r_reg <= '0;
            acc_r_l_reg <= '0;
            acc_r_r_reg <= '0;
        end else if (ctrl.step) begin
            k_reg       <= k_reg + FW'(1);
            acc_q_l_reg <= acc_q_l_next;
            acc_q_r_reg <= acc_q_r_next;
            acc_r_l_reg <= acc_r_l_next;
            acc_r_r_reg <= acc_r_r_next;
        end
        if (ctrl.cap_left) begin
            inc_q_l_reg <= div_q;
            inc_r_l_reg <= div_rem;
        end
        if (ctrl.cap_right) begin
            inc_q_r_reg <= div_q;
            inc_r_r_reg <= div_rem;
        end
        if (ctrl.load_out) begin
            out_l_reg    <= val_l[SW-1:0];
            out_r_reg    <= stereo_reg ? val_r[SW-1:0] : val_l[SW-1:0];
            out_last_reg <= last;
        end
    end

    assign s_ready       = ctrl.s_ready;
    assign m_valid       = ctrl.m_valid;
    assign m_left_out    = out_l_reg;
    assign m_right_out   = out_r_reg;
    assign m_last_of_run = out_last_reg;

endmodule

`default_nettype wire

// File: src/liu_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module liu_div #(
    parameter int NUM_W = liu_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEN_W = $clog2(liu_pkg::MAX_FACTOR_DEF + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient,
    output logic      [DEN_W-1:0] remainder
);
    import liu_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], qbit};
            if (qbit) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[DEN_W-1:0];
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: src/liu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module liu_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire liu_pkg::liu_stat_t  stat,
    output liu_pkg::liu_ctrl_t       ctrl
);
    import liu_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.in_accept) state_next = ST_START_L;
            end
            ST_START_L: state_next = ST_WAIT_L;
            ST_WAIT_L: begin
                if (stat.div_done) state_next = stat.stereo ? ST_START_R : ST_LOAD;
            end
            ST_START_R: state_next = ST_WAIT_R;
            ST_WAIT_R: begin
                if (stat.div_done) state_next = ST_LOAD;
            end
            ST_LOAD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_accept) state_next = stat.last ? ST_IDLE : ST_LOAD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:    ctrl.s_ready = 1'b1;
            ST_START_L: ctrl.div_start = 1'b1;
            ST_WAIT_L:  ctrl.cap_left = stat.div_done;
            ST_START_R: begin
                ctrl.div_start = 1'b1;
                ctrl.div_right = 1'b1;
            end
            ST_WAIT_R:  begin
                ctrl.div_right = 1'b1;
                ctrl.cap_right = stat.div_done;
            end
            ST_LOAD:    ctrl.load_out = 1'b1;
            ST_EMIT: begin
                ctrl.m_valid = 1'b1;
                ctrl.step    = stat.out_accept && !stat.last;
                ctrl.finish  = stat.out_accept && stat.last;
            end
            default:    ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/liu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "linear_interp_upsampler_macros.svh"

module liu_checker #(
    parameter int SAMPLE_WIDTH = liu_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] m_left_out,
    input wire logic signed [SAMPLE_WIDTH-1:0] m_right_out,
    input wire logic                           m_last_of_run
);
    import liu_pkg::*;

    logic                    last_take;
    logic                    out_stall;
    logic [2*SAMPLE_WIDTH:0] out_payload;

    assign last_take   = m_valid && m_ready && m_last_of_run;
    assign out_stall   = m_valid && !m_ready;
    assign out_payload = {m_left_out, m_right_out, m_last_of_run};

    // The block never takes a new item while an output item is on offer.
    `LIU_ASSERT_CLK(a_ready_excl_valid, !(s_ready && m_valid), "s_ready with m_valid")

    // An accepted input item keeps the block busy in the following cycle.
    `LIU_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")

    // Once the last pair of a run is taken the block is idle again.
    `LIU_ASSERT_NEXT(a_idle_after_last, last_take, s_ready && !m_valid, "not idle after last pair")

    // A stalled output item holds its payload.
    `LIU_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(out_payload), "stalled output changed")

endmodule

bind linear_interp_upsampler liu_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_liu_checker (.*);

`default_nettype wire
